// ===== design/kmst_pkg.sv =====
// Shared types and fixed field widths for the spanning-tree edge selector.
`timescale 1ns / 1ps
`default_nettype none

package kmst_pkg;

  localparam int NODE_IN_W = 10;
  localparam int COST_W    = 32;
  localparam int COUNT_W   = 10;
  localparam int CFG_W     = 11;
  localparam int RANK_W    = 4;

  localparam logic [CFG_W-1:0]  NODE_COUNT_RESET = 11'd1024;
  localparam logic [RANK_W-1:0] RANK_MAX         = 4'd15;

  typedef struct packed {
    logic                 new_graph;
    logic [NODE_IN_W-1:0] node_a;
    logic [NODE_IN_W-1:0] node_b;
    logic [COST_W-1:0]    cost_in;
    logic                 last_edge;
  } item_t;

  typedef struct packed {
    logic                 accepted;
    logic [NODE_IN_W-1:0] low_node;
    logic [NODE_IN_W-1:0] high_node;
    logic [COST_W-1:0]    cost_out;
    logic [COUNT_W-1:0]   tree_edges;
    logic                 tree_complete;
    logic                 not_connected;
  } result_t;

endpackage

`default_nettype wire

// ===== design/kmst_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module kmst_ram #(
  parameter int WIDTH = 14,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== design/kruskal_mst_edge_selector_unit.sv =====
// Top level: union-find edge selector for a spanning tree built from sorted edges.
//
//   channel   signals                  direction  timing
//   ------------------------------------------------------------------------
//   item      start, busy, item        in         taken when start && !busy
//   result    done, result             out        one cycle, cannot be held off
//   config    cfg_we, cfg_data         in         node_count written when cfg_we
//
// An edge looks up the root of each endpoint, pointing the nodes on each path
// straight at their root, then joins the two roots by rank, with a second write
// for equal ranks; edges turned away before any lookup (tree complete,
// endpoint out of range) skip all of this. Each cycle makes at most one read
// and one write to the parent/rank memory. After reset, and before an edge
// that carries new_graph, a clearing pass rewrites the table with busy held high.
`timescale 1ns / 1ps
`default_nettype none

module kruskal_mst_edge_selector_unit
  import kmst_pkg::*;
#(
  parameter int MAX_NODES = 1024,
  parameter int COST_BITS = 32
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  output logic                  busy,
  input  wire item_t            item,
  input  wire logic             cfg_we,
  input  wire logic [CFG_W-1:0] cfg_data,
  output logic                  done,
  output result_t               result
);

  localparam int NW  = $clog2(MAX_NODES);
  localparam int CLW = $clog2(MAX_NODES + 1);
  localparam int CW  = (CLW > CFG_W) ? CLW : CFG_W;
  localparam int EW  = NW + RANK_W;
  localparam int CB  = (COST_BITS < COST_W) ? COST_BITS : COST_W;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_CLEAR = 9'b000000010,
    S_EVAL  = 9'b000000100,
    S_FIND  = 9'b000001000,
    S_COMP  = 9'b000010000,
    S_NEXT  = 9'b000100000,
    S_JOIN  = 9'b001000000,
    S_JOIN2 = 9'b010000000,
    S_FIN   = 9'b100000000
  } state_t;

  state_t            state;
  item_t             item_q;
  logic [CFG_W-1:0]  node_count;
  logic [NW-1:0]     clr_idx;
  logic              pend;
  logic              side;
  logic [NW-1:0]     cur;
  logic [NW-1:0]     ra;
  logic [NW-1:0]     rb;
  logic [RANK_W-1:0] rka;
  logic [RANK_W-1:0] rkb;
  logic              acc;
  logic [CW-1:0]     count;
  logic              tree_done;

  logic              we;
  logic [NW-1:0]     waddr;
  logic [EW-1:0]     wdata;
  logic [NW-1:0]     raddr;
  logic [EW-1:0]     rdata;

  logic [NW-1:0]     rd_parent;
  logic [RANK_W-1:0] rd_rank;
  logic [CW-1:0]     a_ext;
  logic [CW-1:0]     b_ext;
  logic [NW-1:0]     a_idx;
  logic [NW-1:0]     b_idx;
  logic [CW-1:0]     nc_ext;
  logic [CW-1:0]     n_eff;
  logic [CW-1:0]     needed;
  logic [CW-1:0]     count_inc;
  logic [NW-1:0]     start_node;
  logic [NW-1:0]     root_sel;
  logic [RANK_W-1:0] rk_inc;

  assign rd_parent  = rdata[EW-1:RANK_W];
  assign rd_rank    = rdata[RANK_W-1:0];
  assign a_ext      = CW'(item_q.node_a);
  assign b_ext      = CW'(item_q.node_b);
  assign a_idx      = a_ext[NW-1:0];
  assign b_idx      = b_ext[NW-1:0];
  assign nc_ext     = CW'(node_count);
  // A zero node count acts as one; anything above the table size is clamped.
  assign n_eff      = (nc_ext == '0) ? CW'(1) :
                      (nc_ext > CW'(MAX_NODES)) ? CW'(MAX_NODES) : nc_ext;
  assign needed     = n_eff - CW'(1);
  assign count_inc  = count + CW'(1);
  assign start_node = side ? b_idx : a_idx;
  assign root_sel   = side ? rb : ra;
  assign rk_inc     = (rka == RANK_MAX) ? rka : rka + RANK_W'(1);
  assign busy       = (state != S_IDLE);

  kmst_ram #(
    .WIDTH(EW),
    .DEPTH(MAX_NODES)
  ) u_table (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_comb begin
    we    = 1'b0;
    waddr = cur;
    wdata = '0;
    raddr = cur;
    case (state)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = clr_idx;
        wdata = {clr_idx, RANK_W'(0)};
      end
      S_EVAL: begin
        raddr = a_idx;
      end
      S_FIND: begin
        // At the root, start the compression walk from the endpoint again.
        raddr = (rd_parent == cur) ? start_node : rd_parent;
      end
      S_COMP: begin
        we    = 1'b1;
        waddr = cur;
        wdata = {root_sel, rd_rank};
        raddr = rd_parent;
      end
      S_NEXT: begin
        raddr = b_idx;
      end
      S_JOIN: begin
        if (ra != rb) begin
          we = 1'b1;
          if (rka < rkb) begin
            waddr = ra;
            wdata = {rb, rka};
          end else begin
            waddr = rb;
            wdata = {ra, rkb};
          end
        end
      end
      S_JOIN2: begin
        we    = 1'b1;
        waddr = ra;
        wdata = {ra, rk_inc};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_idx    <= '0;
      pend       <= 1'b0;
      done       <= 1'b0;
      count      <= '0;
      tree_done  <= 1'b0;
      node_count <= NODE_COUNT_RESET;
    end else begin
      done <= 1'b0;
      if (cfg_we) begin
        node_count <= cfg_data;
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            item_q <= item;
            if (item.new_graph) begin
              state     <= S_CLEAR;
              clr_idx   <= '0;
              pend      <= 1'b1;
              count     <= '0;
              tree_done <= 1'b0;
            end else begin
              state <= S_EVAL;
            end
          end
        end
        S_CLEAR: begin
          clr_idx <= clr_idx + NW'(1);
          if (clr_idx == NW'(MAX_NODES - 1)) begin
            state <= pend ? S_EVAL : S_IDLE;
            pend  <= 1'b0;
          end
        end
        S_EVAL: begin
          acc <= 1'b0;
          if (tree_done || count >= needed) begin
            tree_done <= 1'b1;
            state     <= S_FIN;
          end else if (a_ext < n_eff && b_ext < n_eff) begin
            cur   <= a_idx;
            side  <= 1'b0;
            state <= S_FIND;
          end else begin
            state <= S_FIN;
          end
        end
        S_FIND: begin
          if (rd_parent == cur) begin
            if (side) begin
              rb  <= cur;
              rkb <= rd_rank;
            end else begin
              ra  <= cur;
              rka <= rd_rank;
            end
            if (start_node != cur) begin
              cur   <= start_node;
              state <= S_COMP;
            end else begin
              state <= side ? S_JOIN : S_NEXT;
            end
          end else begin
            cur <= rd_parent;
          end
        end
        S_COMP: begin
          if (rd_parent != root_sel) begin
            cur <= rd_parent;
          end else begin
            state <= side ? S_JOIN : S_NEXT;
          end
        end
        S_NEXT: begin
          side  <= 1'b1;
          cur   <= b_idx;
          state <= S_FIND;
        end
        S_JOIN: begin
          if (ra == rb) begin
            state <= S_FIN;
          end else begin
            acc   <= 1'b1;
            count <= count_inc;
            if (count_inc >= needed) begin
              tree_done <= 1'b1;
            end
            // Equal ranks need a second write to raise the new root's rank.
            state <= (rka == rkb) ? S_JOIN2 : S_FIN;
          end
        end
        S_JOIN2: begin
          state <= S_FIN;
        end
        S_FIN: begin
          result.accepted      <= acc;
          result.low_node      <= (item_q.node_a < item_q.node_b) ? item_q.node_a
                                                                  : item_q.node_b;
          result.high_node     <= (item_q.node_a < item_q.node_b) ? item_q.node_b
                                                                  : item_q.node_a;
          result.cost_out      <= COST_W'(item_q.cost_in[CB-1:0]);
          result.tree_edges    <= count[COUNT_W-1:0];
          result.tree_complete <= tree_done;
          result.not_connected <= item_q.last_edge & ~tree_done;
          done                 <= 1'b1;
          state                <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== design/kmst_checker.sv =====
// Port-level checks for the spanning-tree edge selector, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module kmst_checker
  import kmst_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             start,
  input wire logic             busy,
  input wire logic             done,
  input wire result_t          result
);

  // A result word only follows a cycle in which an edge was being worked on.
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result word without a preceding busy cycle");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe lasted more than one cycle");

  a_accept_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !done))
    else $error("accepted edge did not hold the block busy");

  // A self loop never joins two components.
  a_no_self_loop: assert property (@(posedge clk) disable iff (rst)
    (done && result.accepted) |-> (result.low_node != result.high_node))
    else $error("self loop entered the tree");

  a_not_connected_incomplete: assert property (@(posedge clk) disable iff (rst)
    (done && result.not_connected) |-> !result.tree_complete)
    else $error("complete tree flagged as not connected");

endmodule

bind kruskal_mst_edge_selector_unit kmst_checker u_kmst_checker (
  .clk     (clk),
  .rst     (rst),
  .start   (start),
  .busy    (busy),
  .done    (done),
  .result  (result)
);

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the spanning-tree edge selector, with a union-find predictor.
`timescale 1ns / 1ps

module testbench;
  import kmst_pkg::*;

  typedef struct {
    bit                 set_n;
    logic [CFG_W-1:0]   n_val;
    item_t              word;
    bit                 typed;
    result_t            want;
  } dir_row_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic             busy;
  item_t            item = '0;
  logic             cfg_we = 1'b0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic             done;
  result_t          result;

  // Predictor state: a copy of the forest, the tree progress and the node count.
  logic [NODE_IN_W-1:0] parent_tbl [1024];
  logic [RANK_W-1:0]    rank_tbl [1024];
  int                   tree_count;
  bit                   tree_done;
  logic [CFG_W-1:0]     node_count_set;

  result_t   verdicts_due[$];
  dir_row_t  directed_rows[$];
  int        mismatch_count = 0;
  int        edges_sent = 0;

  kruskal_mst_edge_selector_unit dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .item     (item),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .done     (done),
    .result   (result)
  );

  always #5 clk = ~clk;

  initial begin
    #100_000_000;
    $display("Mismatches found");
    $finish;
  end

  task automatic report_mismatch(string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
    end
  endtask

  function automatic item_t edge_word(bit ng, int a, int b, logic [31:0] c, bit last);
    item_t w;
    w.new_graph = ng;
    w.node_a    = NODE_IN_W'(a);
    w.node_b    = NODE_IN_W'(b);
    w.cost_in   = c;
    w.last_edge = last;
    return w;
  endfunction

  function automatic result_t res_word(bit acc, int lo, int hi, logic [31:0] c, int cnt,
                                       bit cmp, bit nc);
    result_t r;
    r.accepted      = acc;
    r.low_node      = NODE_IN_W'(lo);
    r.high_node     = NODE_IN_W'(hi);
    r.cost_out      = c;
    r.tree_edges    = COUNT_W'(cnt);
    r.tree_complete = cmp;
    r.not_connected = nc;
    return r;
  endfunction

  function automatic void add_row(bit set_n, logic [CFG_W-1:0] n_val, item_t w, bit typed,
                                  result_t want);
    dir_row_t row;
    row.set_n = set_n;
    row.n_val = n_val;
    row.word  = w;
    row.typed = typed;
    row.want  = want;
    directed_rows.insert(directed_rows.size(), row);
  endfunction

  function automatic void clear_forest();
    for (int i = 0; i < 1024; i++) begin
      parent_tbl[i] = NODE_IN_W'(i);
      rank_tbl[i]   = '0;
    end
    tree_count = 0;
    tree_done  = 1'b0;
  endfunction

  // A count of zero behaves as one node, and anything above the table size as the table size.
  function automatic int usable_nodes();
    int n;
    n = int'(node_count_set);
    if (n < 1) n = 1;
    if (n > 1024) n = 1024;
    return n;
  endfunction

  // Walks up to the root, then points every node on the path straight at it.
  function automatic logic [NODE_IN_W-1:0] root_walk(logic [NODE_IN_W-1:0] x);
    logic [NODE_IN_W-1:0] r;
    logic [NODE_IN_W-1:0] nxt;
    int guard;
    r = x;
    guard = 0;
    while (parent_tbl[r] != r && guard < 1024) begin
      r = parent_tbl[r];
      guard++;
    end
    while (x != r) begin
      nxt = parent_tbl[x];
      parent_tbl[x] = r;
      x = nxt;
    end
    return r;
  endfunction

  function automatic result_t select_edge(item_t w);
    int n;
    int needed;
    bit acc;
    logic [NODE_IN_W-1:0] ra;
    logic [NODE_IN_W-1:0] rb;
    result_t r;
    if (w.new_graph) clear_forest();
    n = usable_nodes();
    needed = n - 1;
    if (tree_count >= needed) tree_done = 1'b1;
    acc = 1'b0;
    if (!tree_done && w.node_a < n && w.node_b < n) begin
      ra = root_walk(w.node_a);
      rb = root_walk(w.node_b);
      if (ra != rb) begin
        if (rank_tbl[ra] < rank_tbl[rb]) begin
          parent_tbl[ra] = rb;
        end else if (rank_tbl[ra] > rank_tbl[rb]) begin
          parent_tbl[rb] = ra;
        end else begin
          parent_tbl[rb] = ra;
          if (rank_tbl[ra] < RANK_MAX) rank_tbl[ra] = rank_tbl[ra] + 1'b1;
        end
        tree_count++;
        acc = 1'b1;
        if (tree_count >= needed) tree_done = 1'b1;
      end
    end
    r = res_word(acc, int'((w.node_a < w.node_b) ? w.node_a : w.node_b),
                 int'((w.node_a < w.node_b) ? w.node_b : w.node_a),
                 w.cost_in, tree_count, tree_done, w.last_edge && !tree_done);
    return r;
  endfunction

  // Leaves the clock at the edge where the word was taken, with start still high.
  task automatic send_edge(item_t w, bit typed, result_t want);
    result_t predicted;
    start <= 1'b1;
    item  <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    predicted = select_edge(w);
    verdicts_due.insert(verdicts_due.size(), typed ? want : predicted);
  endtask

  task automatic idle_gap(int pct);
    if ($urandom_range(99) < pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // The node count is only changed once every outstanding word has come back.
  task automatic set_node_count(logic [CFG_W-1:0] v);
    start <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    while (busy) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    node_count_set = v;
  endtask

  task automatic run_graphs(int idle_pct, int quota);
    int pick;
    int v;
    int n;
    int len;
    int kind;
    int a;
    int b;
    int last_pos;
    bit fresh;
    bit ng;
    longint cost;
    while (edges_sent < quota) begin
      pick = $urandom_range(99);
      v = -1;
      if (pick < 30) v = $urandom_range(2, 12);
      else if (pick < 50) v = $urandom_range(13, 64);
      else if (pick < 58) v = $urandom_range(65, 1024);
      else if (pick < 68) begin
        case ($urandom_range(4))
          0: v = 0;
          1: v = 1;
          2: v = 2;
          3: v = 1024;
          default: v = 2047;
        endcase
      end else if (pick < 78) v = $urandom_range(0, 2047);
      if (v >= 0) set_node_count(CFG_W'(v));
      n = usable_nodes();
      if (n <= 64) begin
        len = $urandom_range((n - 1 > 4) ? n - 1 : 4, 3 * n + 4);
        if (len > 80) len = 80;
      end else begin
        len = $urandom_range(4, 40);
      end
      fresh = ($urandom_range(99) < 92);
      pick = $urandom_range(99);
      if (pick < 85) last_pos = len - 1;
      else if (pick < 92) last_pos = -1;
      else last_pos = $urandom_range(0, len - 1);
      cost = $urandom_range(1) ? longint'($urandom_range(0, 255)) : longint'($urandom());
      for (int i = 0; i < len; i++) begin
        kind = $urandom_range(99);
        a = $urandom_range(0, n - 1);
        b = $urandom_range(0, n - 1);
        if (kind < 5) begin
          b = a;
        end else if (kind < 10) begin
          if (n < 1024) a = $urandom_range(n, 1023);
        end else if (kind < 15) begin
          a = $urandom_range(0, 1023);
          b = $urandom_range(0, 1023);
        end
        if ($urandom_range(99) < 3) cost = longint'($urandom());
        else if ($urandom_range(3) == 0) cost = cost + $urandom_range(0, 1000);
        if (cost > 64'hFFFF_FFFF) cost = 64'hFFFF_FFFF;
        ng = (i == 0) ? fresh : ($urandom_range(99) < 2);
        idle_gap(idle_pct);
        send_edge(edge_word(ng, a, b, cost[31:0], i == last_pos), 1'b0, '0);
        edges_sent++;
      end
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst && done) begin
      if (verdicts_due.size() == 0) begin
        report_mismatch("result word with nothing expected");
      end else begin
        want = verdicts_due.pop_front();
        check_field("accepted", result.accepted, want.accepted);
        check_field("low_node", result.low_node, want.low_node);
        check_field("high_node", result.high_node, want.high_node);
        check_field("cost_out", result.cost_out, want.cost_out);
        check_field("tree_edges", result.tree_edges, want.tree_edges);
        check_field("tree_complete", result.tree_complete, want.tree_complete);
        check_field("not_connected", result.not_connected, want.not_connected);
      end
    end
  end

  initial begin
    int waited;
    node_count_set = NODE_COUNT_RESET;
    clear_forest();

    // Rows with a typed-in word hold cases whose outcome is plain from the rules.
    add_row(0, 0, edge_word(0, 0, 1023, 0, 0), 1,
            res_word(1, 0, 1023, 0, 1, 0, 0));
    add_row(0, 0, edge_word(0, 1023, 0, 5, 0), 1,
            res_word(0, 0, 1023, 5, 1, 0, 0));
    add_row(0, 0, edge_word(0, 5, 5, 7, 0), 1,
            res_word(0, 5, 5, 7, 1, 0, 0));
    add_row(0, 0, edge_word(0, 1, 2, 32'hFFFF_FFFF, 1), 1,
            res_word(1, 1, 2, 32'hFFFF_FFFF, 2, 0, 1));
    add_row(1, 3, edge_word(1, 0, 1, 10, 0), 1,
            res_word(1, 0, 1, 10, 1, 0, 0));
    add_row(0, 0, edge_word(0, 2, 3, 10, 0), 1,
            res_word(0, 2, 3, 10, 1, 0, 0));
    add_row(0, 0, edge_word(0, 1, 2, 11, 0), 1,
            res_word(1, 1, 2, 11, 2, 1, 0));
    add_row(0, 0, edge_word(0, 0, 2, 12, 1), 1,
            res_word(0, 0, 2, 12, 2, 1, 0));
    add_row(1, 1, edge_word(1, 0, 0, 0, 1), 1,
            res_word(0, 0, 0, 0, 0, 1, 0));
    add_row(1, 0, edge_word(1, 0, 1, 1, 0), 1,
            res_word(0, 0, 1, 1, 0, 1, 0));
    add_row(1, 2047, edge_word(1, 1023, 512, 20, 1), 1,
            res_word(1, 512, 1023, 20, 1, 0, 1));
    add_row(1, 2, edge_word(1, 1, 0, 3, 0), 1,
            res_word(1, 0, 1, 3, 1, 1, 0));
    add_row(0, 0, edge_word(0, 0, 1, 4, 1), 1,
            res_word(0, 0, 1, 4, 1, 1, 0));
    add_row(1, 4, edge_word(1, 0, 1, 1, 0), 0, '0);
    add_row(0, 0, edge_word(0, 2, 3, 1, 0), 0, '0);
    add_row(0, 0, edge_word(0, 1, 3, 2, 0), 0, '0);
    add_row(0, 0, edge_word(0, 0, 2, 2, 1), 0, '0);
    // A larger count does not reopen a finished tree until the next graph starts.
    add_row(1, 5, edge_word(0, 3, 4, 9, 0), 0, '0);
    add_row(0, 0, edge_word(1, 4, 0, 9, 1), 0, '0);
    add_row(1, 1024, edge_word(1, 1022, 1023, 0, 0), 0, '0);

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].set_n) set_node_count(directed_rows[i].n_val);
      idle_gap(13);
      send_edge(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].want);
    end

    run_graphs(13, 367);
    run_graphs(58, 734);
    run_graphs(0, 1100);

    start <= 1'b0;
    waited = 0;
    while (verdicts_due.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (60) @(posedge clk);
    if (verdicts_due.size() != 0) begin
      report_mismatch($sformatf("%0d expected words never arrived", verdicts_due.size()));
    end

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
